[src/ssc_pkg.sv]
package ssc_pkg;

    // Fixed field widths
    localparam int TARGET_W = 10;
    localparam int ELEM_W   = 16;
    localparam int OUT_W    = 32;

    // Defaults for the top-level parameters
    localparam int MAX_SUM_DEF     = 1023;
    localparam int COUNT_WIDTH_DEF = 32;

    // Widest count the clamp logic handles
    localparam int COUNT_W_MAX = 64;

endpackage

[src/ssc_table.sv]
// Count table: one write port, two registered read ports.
module ssc_table #(
    parameter int DEPTH   = ssc_pkg::MAX_SUM_DEF + 1,
    parameter int AW      = $clog2(ssc_pkg::MAX_SUM_DEF + 1),
    parameter int COUNT_W = ssc_pkg::COUNT_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr_a,
    input  logic [AW-1:0]      rd_addr_b,
    output logic [COUNT_W-1:0] rd_data_a,
    output logic [COUNT_W-1:0] rd_data_b,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [COUNT_W-1:0] wr_data
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] q_a_reg;
    logic [COUNT_W-1:0] q_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_a_reg <= mem[rd_addr_a];
            q_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = q_a_reg;
    assign rd_data_b = q_b_reg;

endmodule

[src/ssc_seq.sv]
// Sequencer: clear sweep, per-word table walk, result fetch.
module ssc_seq #(
    parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF,
    parameter int AW      = $clog2(ssc_pkg::MAX_SUM_DEF + 1),
    parameter int COUNT_W = ssc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ssc_pkg::ELEM_W-1:0]    elem,
    input  logic                          last,
    input  logic [ssc_pkg::TARGET_W-1:0]  target,
    input  logic                          out_free,
    output logic                          res_valid,
    output logic [ssc_pkg::OUT_W-1:0]     res_count,
    output logic                          res_sat,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr_a,
    output logic [AW-1:0]                 rd_addr_b,
    input  logic [COUNT_W-1:0]            rd_data_a,
    input  logic [COUNT_W-1:0]            rd_data_b,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [COUNT_W-1:0]            wr_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FETCH,
        ST_WAITRD
    } state_t;

    state_t                      state_reg, state_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [AW-1:0]               hi_reg, hi_next;
    logic [ssc_pkg::ELEM_W-1:0]  v_reg, v_next;
    logic                        last_reg, last_next;
    logic [AW-1:0]               t_reg, t_next;
    logic [AW-1:0]               s_reg, s_next;
    logic                        p_vld_reg, p_vld_next;
    logic [AW-1:0]               p_addr_reg, p_addr_next;
    logic                        sat_reg, sat_next;

    logic [AW-1:0]               t_eff;
    logic                        fits;
    logic [COUNT_W:0]            sum_wide;
    logic                        ovf;
    logic [ssc_pkg::COUNT_W_MAX-1:0] count_ext;
    logic                        clamp;

    assign t_eff = (32'(target) > 32'(MAX_SUM)) ? AW'(MAX_SUM) : AW'(target);
    assign fits  = (32'(elem) <= 32'(t_eff));

    // saturating add in the write stage
    assign sum_wide = {1'b0, rd_data_a} + {1'b0, rd_data_b};
    assign ovf      = sum_wide[COUNT_W];

    // clamp to the output width
    assign count_ext = ssc_pkg::COUNT_W_MAX'(rd_data_a);
    assign clamp     = |count_ext[ssc_pkg::COUNT_W_MAX-1:ssc_pkg::OUT_W];

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_WAITRD) && out_free;
    assign res_count = clamp ? '1 : count_ext[ssc_pkg::OUT_W-1:0];
    assign res_sat   = sat_reg | clamp;

    assign rd_en     = (state_reg == ST_RUN) || (state_reg == ST_FETCH);
    assign rd_addr_a = (state_reg == ST_FETCH) ? t_reg : s_reg;
    assign rd_addr_b = s_reg - AW'(v_reg);
    assign wr_en     = (state_reg == ST_CLEAR) || p_vld_reg;
    assign wr_addr   = (state_reg == ST_CLEAR) ? clr_reg : p_addr_reg;
    // sweep writes the cleared value: one at sum 0, zero elsewhere
    assign wr_data   = (state_reg == ST_CLEAR) ? ((clr_reg == '0) ? COUNT_W'(1) : '0)
                                               : (ovf ? '1 : sum_wide[COUNT_W-1:0]);

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        hi_next     = hi_reg;
        v_next      = v_reg;
        last_next   = last_reg;
        t_next      = t_reg;
        s_next      = s_reg;
        p_vld_next  = 1'b0;
        p_addr_next = p_addr_reg;
        sat_next    = sat_reg | (p_vld_reg & ovf);

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                // entries above the highest walked target were never written
                if (clr_reg == hi_reg) begin
                    clr_next   = '0;
                    hi_next    = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    v_next    = elem;
                    last_next = last;
                    t_next    = t_eff;
                    s_next    = t_eff;
                    if (fits) begin
                        if (t_eff > hi_reg) begin
                            hi_next = t_eff;
                        end
                        state_next = ST_RUN;
                    end else if (last) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_RUN: begin
                p_vld_next  = 1'b1;
                p_addr_next = s_reg;
                if (s_reg == AW'(v_reg)) begin
                    state_next = ST_DRAIN;
                end else begin
                    s_next = s_reg - AW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = last_reg ? ST_FETCH : ST_IDLE;
            end
            ST_FETCH: begin
                state_next = ST_WAITRD;
            end
            ST_WAITRD: begin
                if (out_free) begin
                    sat_next   = 1'b0;
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            hi_reg    <= AW'(MAX_SUM);
            p_vld_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hi_reg    <= hi_next;
            p_vld_reg <= p_vld_next;
            sat_reg   <= sat_next;
        end
        v_reg      <= v_next;
        last_reg   <= last_next;
        t_reg      <= t_next;
        s_reg      <= s_next;
        p_addr_reg <= p_addr_next;
    end

endmodule

[src/subset_sum_counter.sv]
// subset_sum_counter
// Counts the subsets of a stream of words whose values add up to the
// target held in the configuration register (cfg_wr_en / cfg_wr_data).
// Input channel s_*: one element per word; s_set_end marks the last
// element of a set. Result channel m_*: one word per set, giving the
// count at the target and a flag that is high if any count saturated.
// A count table of MAX_SUM+1 entries lives in a RAM with two registered
// read ports and one write port. An element v <= T (T = target clamped to
// MAX_SUM) walks the table from T down to v, one read-modify-write per
// cycle; an element above T leaves the table untouched. After the final
// element of a set the count at T is read and, once the output register
// is free, loaded into the result word; then a sweep clears entries 0..H,
// H being the highest T walked in the set (0 if none), with s_ready low.
// After reset a sweep clears all MAX_SUM+1 entries, with s_ready low.
// Results sit in an output register: while m_ready is low the block keeps
// taking elements and stalls only when a second result is ready.
// Write the target only while the block is idle.
module subset_sum_counter #(
    parameter int MAX_SUM     = ssc_pkg::MAX_SUM_DEF,
    parameter int COUNT_WIDTH = ssc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ssc_pkg::TARGET_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ssc_pkg::ELEM_W-1:0]    s_element_value,
    input  logic                          s_set_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ssc_pkg::OUT_W-1:0]     m_subset_count,
    output logic                          m_count_saturated
);

    localparam int DEPTH = MAX_SUM + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ssc_pkg::TARGET_W-1:0] target_reg;

    // output register
    logic                         m_valid_reg;
    logic [ssc_pkg::OUT_W-1:0]    m_count_reg;
    logic                         m_sat_reg;
    logic                         out_free;

    logic                         res_valid;
    logic [ssc_pkg::OUT_W-1:0]    res_count;
    logic                         res_sat;

    // table port signals
    logic                         rd_en;
    logic [AW-1:0]                rd_addr_a;
    logic [AW-1:0]                rd_addr_b;
    logic [COUNT_WIDTH-1:0]       rd_data_a;
    logic [COUNT_WIDTH-1:0]       rd_data_b;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [COUNT_WIDTH-1:0]       wr_data;

    assign out_free          = !m_valid_reg || m_ready;
    assign m_valid           = m_valid_reg;
    assign m_subset_count    = m_count_reg;
    assign m_count_saturated = m_sat_reg;

    // target register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    // result register: loads when the sequencer hands over a word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_count_reg <= res_count;
            m_sat_reg   <= res_sat;
        end
    end

    ssc_seq #(
        .MAX_SUM (MAX_SUM),
        .AW      (AW),
        .COUNT_W (COUNT_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .elem      (s_element_value),
        .last      (s_set_end),
        .target    (target_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_count (res_count),
        .res_sat   (res_sat),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ssc_table #(
        .DEPTH   (DEPTH),
        .AW      (AW),
        .COUNT_W (COUNT_WIDTH)
    ) u_table (
        .aclk      (aclk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

endmodule

[dv/ssc_checker.sv]
module ssc_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ssc_pkg::TARGET_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [ssc_pkg::ELEM_W-1:0]   s_element_value,
    input  logic                         s_set_end,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [ssc_pkg::OUT_W-1:0]    m_subset_count,
    input  logic                         m_count_saturated,
    output int                           fail_count,
    output int                           pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = ssc_pkg::COUNT_WIDTH_DEF;
    localparam int MAX_SUM_DEF = ssc_pkg::MAX_SUM_DEF;
    localparam int TARGET_W    = ssc_pkg::TARGET_W;
    localparam int ELEM_W      = ssc_pkg::ELEM_W;
    localparam int OUT_W       = ssc_pkg::OUT_W;

    typedef struct packed {
        logic [OUT_W-1:0] count;
        logic             sat;
    } count_word_t;

    // shadow of the count table, indexed by partial sum
    logic [CW-1:0]    ways [0:MAX_SUM_DEF];
    logic             sat_seen;
    logic [TARGET_W-1:0] target_q;
    count_word_t      expected_counts [$];
    int               fails = 0;

    task automatic clear_ways();
        for (int i = 0; i <= MAX_SUM_DEF; i++) begin
            ways[i] = '0;
        end
        ways[0]  = 1;
        sat_seen = 1'b0;
    endtask

    // apply one element; on the last one of a set, queue the count at target
    task automatic fold_element(input logic [ELEM_W-1:0] v, input logic last);
        int t;
        int s;
        logic [CW:0] sum;
        count_word_t w;
        t = (int'(target_q) > MAX_SUM_DEF) ? MAX_SUM_DEF : int'(target_q);
        if (int'(v) <= t) begin
            for (s = t; s >= int'(v); s--) begin
                sum = {1'b0, ways[s]} + {1'b0, ways[s - int'(v)]};
                if (sum[CW]) begin
                    ways[s]  = '1;
                    sat_seen = 1'b1;
                end else begin
                    ways[s] = sum[CW-1:0];
                end
            end
        end
        if (last) begin
            w.sat = sat_seen;
            // clamp only matters when counts are wider than the output
            if (CW > OUT_W && (64'(ways[t]) >> OUT_W) != 0) begin
                w.count = '1;
                w.sat   = 1'b1;
            end else begin
                w.count = OUT_W'(ways[t]);
            end
            expected_counts.push_back(w);
            clear_ways();
        end
    endtask

    always @(posedge aclk) begin
        count_word_t w;
        if (!aresetn) begin
            clear_ways();
            target_q = '0;
            expected_counts.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word count=%0d sat=%0d",
                             $time, m_subset_count, m_count_saturated);
                end else begin
                    w = expected_counts.pop_front();
                    if (m_subset_count !== w.count) begin
                        fails++;
                        $display("%0t: subset_count expected %0d actual %0d",
                                 $time, w.count, m_subset_count);
                    end
                    if (m_count_saturated !== w.sat) begin
                        fails++;
                        $display("%0t: count_saturated expected %0d actual %0d",
                                 $time, w.sat, m_count_saturated);
                    end
                end
            end
            if (cfg_wr_en) begin
                target_q = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                fold_element(s_element_value, s_set_end);
            end
        end
        pending_words <= expected_counts.size();
        fail_count    <= fails;
    end

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SUM_DEF = ssc_pkg::MAX_SUM_DEF;
    localparam int TARGET_W    = ssc_pkg::TARGET_W;
    localparam int ELEM_W      = ssc_pkg::ELEM_W;
    localparam int OUT_W       = ssc_pkg::OUT_W;

    // long enough for the longest element walk or the longest clearing
    // sweep to finish, with margin
    localparam int DRAIN_CYCLES = MAX_SUM_DEF + 64;
    // receiver hold-off, long enough for the block to fill up and stall
    localparam int HOLD_CYCLES  = 800;
    localparam int NUM_PHASES   = 15;

    logic                aclk              = 1'b0;
    logic                aresetn           = 1'b0;
    logic                cfg_wr_en         = 1'b0;
    logic [TARGET_W-1:0] cfg_wr_data       = '0;
    logic                s_valid           = 1'b0;
    logic                s_ready;
    logic [ELEM_W-1:0]   s_element_value   = '0;
    logic                s_set_end         = 1'b0;
    logic                m_valid;
    logic                m_ready           = 1'b0;
    logic [OUT_W-1:0]    m_subset_count;
    logic                m_count_saturated;

    int fail_count;
    int pending_words;

    // stimulus knobs shared by the sender and receiver processes
    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;
    int target_now   = 0;

    always #1 aclk = ~aclk;

    subset_sum_counter i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_element_value   (s_element_value),
        .s_set_end         (s_set_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_subset_count    (m_subset_count),
        .m_count_saturated (m_count_saturated)
    );

    ssc_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_element_value   (s_element_value),
        .s_set_end         (s_set_end),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_subset_count    (m_subset_count),
        .m_count_saturated (m_count_saturated),
        .fail_count        (fail_count),
        .pending_words     (pending_words)
    );

    // Gap length for either side: mostly none or short, now and then long.
    // no_idle forces back-to-back traffic for a whole phase.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // Element values biased toward the live part of the table (<= target),
    // with exact hits, zeros, and full-width words that fall above target.
    function automatic logic [ELEM_W-1:0] pick_element(int t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 70) return ELEM_W'($urandom_range(1, (t > 0) ? t : 1));
        if (r < 80) return ELEM_W'(t);
        if (r < 90) return ELEM_W'($urandom_range(0, 15));
        return ELEM_W'($urandom);
    endfunction

    // Offer one word and hold it until accepted. If no gap follows, valid
    // stays high so the next word goes out back to back.
    task automatic send_word(input logic [ELEM_W-1:0] v, input logic last);
        int gap;
        s_valid         <= 1'b1;
        s_element_value <= v;
        s_set_end       <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Target register write; only called with the block idle.
    task automatic load_target(input int t);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= TARGET_W'(t);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        target_now  = t;
    endtask

    // Stop offering, wait for every expected result, then let any element
    // walk or clearing sweep still in flight finish.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One random set. Small targets sometimes get a long burst of mostly
    // zeros: each zero doubles the table, so ~32 of them hit the count limit.
    task automatic send_set(output int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12 && target_now <= 64) begin
            n = $urandom_range(33, 40);
        end else if (r < 22) begin
            n = $urandom_range(7, 16);
        end else begin
            n = $urandom_range(1, 6);
        end
        for (int i = 0; i < n; i++) begin
            if (r < 12 && target_now <= 64 && $urandom_range(0, 99) < 85) begin
                send_word('0, i == n - 1);
            end else begin
                send_word(pick_element(target_now), i == n - 1);
            end
        end
    endtask

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial begin
        int on_len;
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            on_len = $urandom_range(1, 20);
            m_ready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int phase_target [NUM_PHASES];
        int phase_budget [NUM_PHASES];
        int sent;
        int n;
        bit retargeted;

        phase_target = '{1023, 0, 7, 3, 40, 250, 12, 1, 1023, 511, 600, 2, 900, 20, 5};
        phase_budget = '{25, 50, 50, 60, 50, 30, 50, 40, 15, 20, 20, 40, 15, 50, 45};
        phase_target[4]  = $urandom_range(16, 80);
        phase_target[10] = $urandom_range(0, 1023);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing sweep runs after reset with s_ready low
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        // --- directed part ---
        // widest target: zero doubles the whole table, then extremes of
        // the element range, max walk with value 1
        load_target(1023);
        send_word('0, 1'b0);
        send_word(ELEM_W'(1023), 1'b0);
        send_word('1, 1'b0);
        send_word(ELEM_W'(1), 1'b0);
        send_word(ELEM_W'(1022), 1'b1);
        send_word('0, 1'b1);
        drain();

        // target zero: only entry 0 is live; anything nonzero is above target
        load_target(0);
        send_word('0, 1'b1);
        send_word(ELEM_W'(5), 1'b1);
        send_word('1, 1'b1);
        drain();

        // element equal to target, mix below and above target, zero at the end
        load_target(10);
        send_word(ELEM_W'(10), 1'b1);
        send_word(ELEM_W'(3), 1'b0);
        send_word(ELEM_W'(7), 1'b0);
        send_word(ELEM_W'(11), 1'b0);
        send_word('0, 1'b1);
        drain();

        // target moved down while a set is open: entries above it keep values
        load_target(20);
        send_word(ELEM_W'(4), 1'b0);
        send_word(ELEM_W'(6), 1'b0);
        drain();
        load_target(5);
        send_word(ELEM_W'(5), 1'b0);
        send_word('0, 1'b1);
        drain();

        // --- random part ---
        for (int p = 0; p < NUM_PHASES; p++) begin
            load_target(phase_target[p]);
            no_idle = (p % 5 == 2) || (p == 3);
            // phase 3: short sets at a small target while the receiver
            // holds off, so results back up and the input stalls
            if (p == 3) hold_off_req = 1'b1;
            sent = 0;
            retargeted = 1'b0;
            while (sent < phase_budget[p]) begin
                if (p == 6 && !retargeted && sent >= phase_budget[p] / 2) begin
                    // open a set, let it settle, then change the target
                    send_word(pick_element(target_now), 1'b0);
                    drain();
                    load_target($urandom_range(3, 30));
                    retargeted = 1'b1;
                    sent++;
                end
                send_set(n);
                sent += n;
            end
            drain();
        end
        no_idle = 1'b0;

        if (fail_count == 0 && pending_words == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[files.f]
src/ssc_pkg.sv
src/ssc_table.sv
src/ssc_seq.sv
src/subset_sum_counter.sv
dv/ssc_checker.sv
dv/testbench.sv
